// ===== rtl/core/adts_pkg.sv =====
// ----------------------------------------------------------------------------
// adts_pkg
// Shared types and constants for the ADTS frame synchronizer.
// ----------------------------------------------------------------------------
package adts_pkg;

    localparam int WINDOW_BYTES_DEF = 9;
    localparam int HDR_BYTES        = 7;
    localparam int LEN_W            = 13;
    localparam int COUNT_W          = 32;
    localparam int SPF_SHIFT        = 10;

    localparam logic [11:0]      SYNC_WORD      = 12'hFFF;
    localparam logic [1:0]       LAYER_ADTS     = 2'd0;
    localparam logic [3:0]       MAX_RATE_INDEX = 4'd12;
    localparam logic [LEN_W-1:0] MIN_LEN_PLAIN  = 13'd7;
    localparam logic [LEN_W-1:0] MIN_LEN_CRC    = 13'd9;

    typedef struct packed {
        logic             crc_present;
        logic [1:0]       object_profile;
        logic [2:0]       channel_config;
        logic [1:0]       extra_blocks;
        logic [3:0]       rate_index;
        logic [LEN_W-1:0] frame_bytes;
    } hdr_fields_t;

    typedef struct packed {
        logic               keep;
        logic               frame_start;
        logic               frame_end;
        hdr_fields_t        hdr;
        logic [LEN_W-1:0]   samples_per_frame;
        logic [COUNT_W-1:0] frames_done;
    } frame_result_t;

endpackage

// ===== rtl/core/adts_frame_sync.sv =====
// ----------------------------------------------------------------------------
// adts_frame_sync
// ADTS frame synchronizer: hunts for AAC ADTS headers in a byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per word and returns one word per byte once the first nine
// bytes have filled the look-ahead window; each output word carries the byte
// leaving the window, keep/frame_start in m_tuser, frame_end on m_tlast and
// the current frame's header fields and completed-frame count. Throughput is
// one word per cycle while m_tready is high: the header check, byte countdown and
// frame counter sit in a single combinational pass between the window register
// and the output register, so the first result appears in the cycle after the
// tenth byte is accepted, and a byte leaves after its ninth successor enters.
// ----------------------------------------------------------------------------
module adts_frame_sync
    import adts_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // out_byte, frame_bytes, rate_index, samples_per_frame,
                                   // channel_config, object_profile, crc_present,
                                   // frames_done, zero pad
    output logic        m_tlast,   // frame_end
    output logic [1:0]  m_tuser    // keep, frame_start
);

    logic                         accept;
    logic                         advance;
    logic                         full;
    logic [WINDOW_BYTES-1:0][7:0] win_bytes;
    hdr_fields_t                  hdr_new;
    logic                         hdr_ok;
    frame_result_t                result;

    logic          m_valid_reg;
    logic          m_valid_next;
    frame_result_t res_reg;
    logic [7:0]    byte_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign advance  = accept && full;

    adts_window #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (accept),
        .din       (s_tdata),
        .win_bytes (win_bytes),
        .full      (full)
    );

    adts_hdr_check u_hdr_check (
        .hdr_bytes (win_bytes[HDR_BYTES-1:0]),
        .fields    (hdr_new),
        .hdr_ok    (hdr_ok)
    );

    adts_frame_track u_frame_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .hdr_ok  (hdr_ok),
        .hdr_new (hdr_new),
        .result  (result)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (advance)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg  <= result;
            byte_reg <= win_bytes[0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = res_reg.frame_end;
    assign m_tuser  = {res_reg.frame_start, res_reg.keep};
    assign m_tdata  = {4'b0,
                       res_reg.frames_done,
                       res_reg.hdr.crc_present,
                       res_reg.hdr.object_profile,
                       res_reg.hdr.channel_config,
                       res_reg.samples_per_frame,
                       res_reg.hdr.rate_index,
                       res_reg.hdr.frame_bytes,
                       byte_reg};

endmodule

// ===== rtl/core/adts_window.sv =====
// ----------------------------------------------------------------------------
// adts_window
// Look-ahead shift window with fill count; oldest byte at index zero.
// ----------------------------------------------------------------------------
module adts_window
    import adts_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift_en,
    input  logic [7:0]                   din,
    output logic [WINDOW_BYTES-1:0][7:0] win_bytes,
    output logic                         full
);

    localparam int FILL_W = $clog2(WINDOW_BYTES + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_BYTES);

    logic [WINDOW_BYTES-1:0][7:0] win_reg;
    logic [WINDOW_BYTES-1:0][7:0] win_next;
    logic [FILL_W-1:0]            fill_reg;
    logic [FILL_W-1:0]            fill_next;

    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (shift_en)
        begin
            for (int i = 0; i < WINDOW_BYTES - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[WINDOW_BYTES-1] = din;
            if (fill_reg != FILL_MAX)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            win_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            win_reg  <= win_next;
        end
    end

    assign win_bytes = win_reg;
    assign full      = (fill_reg == FILL_MAX);

endmodule

// ===== rtl/core/adts_hdr_check.sv =====
// ----------------------------------------------------------------------------
// adts_hdr_check
// Decodes the head of the window as an ADTS header and checks it.
// ----------------------------------------------------------------------------
module adts_hdr_check
    import adts_pkg::*;
(
    input  logic [HDR_BYTES-1:0][7:0] hdr_bytes,
    output hdr_fields_t               fields,
    output logic                      hdr_ok
);

    logic [11:0]      sync;
    logic [1:0]       layer;
    logic [LEN_W-1:0] min_len;

    always_comb
    begin
        sync                  = {hdr_bytes[0], hdr_bytes[1][7:4]};
        layer                 = hdr_bytes[1][2:1];
        fields.crc_present    = ~hdr_bytes[1][0];
        fields.object_profile = hdr_bytes[2][7:6];
        fields.rate_index     = hdr_bytes[2][5:2];
        fields.channel_config = {hdr_bytes[2][0], hdr_bytes[3][7:6]};
        fields.frame_bytes    = {hdr_bytes[3][1:0], hdr_bytes[4], hdr_bytes[5][7:5]};
        fields.extra_blocks   = hdr_bytes[6][1:0];
        min_len               = fields.crc_present ? MIN_LEN_CRC : MIN_LEN_PLAIN;
        hdr_ok                = (sync == SYNC_WORD)
                             && (layer == LAYER_ADTS)
                             && (fields.rate_index <= MAX_RATE_INDEX)
                             && (fields.frame_bytes >= min_len);
    end

endmodule

// ===== rtl/core/adts_frame_track.sv =====
// ----------------------------------------------------------------------------
// adts_frame_track
// Frame byte countdown, latched header fields and completed-frame counter.
// ----------------------------------------------------------------------------
module adts_frame_track
    import adts_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          hdr_ok,
    input  hdr_fields_t   hdr_new,
    output frame_result_t result
);

    logic [LEN_W-1:0]   bytes_left_reg;
    logic [LEN_W-1:0]   bytes_left_next;
    hdr_fields_t        hdr_reg;
    hdr_fields_t        hdr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               open_now;
    logic [LEN_W-1:0]   left_eff;
    logic [2:0]         blocks;

    always_comb
    begin
        open_now = (bytes_left_reg == '0) && hdr_ok;
        left_eff = open_now ? hdr_new.frame_bytes : bytes_left_reg;
        hdr_next = open_now ? hdr_new : hdr_reg;

        result.keep        = (left_eff != '0);
        result.frame_start = open_now;
        result.frame_end   = (left_eff == LEN_W'(1));
        bytes_left_next    = result.keep ? left_eff - LEN_W'(1) : '0;
        count_next         = result.frame_end ? count_reg + COUNT_W'(1) : count_reg;

        blocks                   = {1'b0, hdr_next.extra_blocks} + 3'd1;
        result.hdr               = hdr_next;
        result.samples_per_frame = {blocks, SPF_SHIFT'(0)};
        result.frames_done       = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            hdr_reg        <= '0;
            count_reg      <= '0;
        end
        else if (advance)
        begin
            bytes_left_reg <= bytes_left_next;
            hdr_reg        <= hdr_next;
            count_reg      <= count_next;
        end
    end

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !result.frame_end |=> count_reg == $past(count_reg))
        else $error("frame counter moved without a frame end");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.frame_end |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("frame counter missed a frame end");

    a_start_keep: assert property (@(posedge clk) disable iff (!rst_n)
        result.frame_start |-> result.keep && (bytes_left_reg == '0))
        else $error("frame start outside hunting or without keep");

    a_hunt_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg == '0) && !hdr_ok |-> !result.keep)
        else $error("byte kept while hunting without a header");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ADTS frame synchronizer.
// ----------------------------------------------------------------------------
// A byte-level tracker mirrors the look-ahead window, the header hunt and the
// frame countdown, and queues one expected output word per accepted byte once
// the window is full. Every output word is compared field by field with the
// oldest queued word. Stimulus runs from a few hand-built headers through
// long stretches of well-formed frames mixed with broken headers and junk,
// with random gaps on both sides, a long receiver stall and a full drain.
// ----------------------------------------------------------------------------
module testbench;

    import adts_pkg::*;

    localparam int WIN_BYTES   = WINDOW_BYTES_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int FLUSH_WAIT  = 20;

    typedef struct {
        logic [7:0]         out_byte;
        logic               keep;
        logic               frame_start;
        logic               frame_end;
        hdr_fields_t        hdr;
        logic [LEN_W-1:0]   samples_per_frame;
        logic [COUNT_W-1:0] frames_done;
    } sync_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    // tracker state
    logic [7:0]         win_bytes [WIN_BYTES];
    int unsigned        win_fill = 0;
    logic [LEN_W-1:0]   bytes_to_go = '0;
    hdr_fields_t        latched_hdr = '0;
    logic [COUNT_W-1:0] frame_count = '0;

    sync_word_t  pending_words [$];
    logic [7:0]  stage_bytes [$];

    int          fail_count = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;
    int          rx_hold_len = 0;
    bit          tx_gaps = 1'b1;
    bit          rx_gaps = 1'b1;

    adts_frame_sync u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        foreach (win_bytes[i])
            win_bytes[i] = 8'd0;
    end

    task automatic track_byte(input logic [7:0] b);
        sync_word_t       w;
        logic [11:0]      sync;
        logic [1:0]       layer;
        logic             crc;
        logic [3:0]       rate;
        logic [LEN_W-1:0] flen;
        logic [LEN_W-1:0] min_len;
        if (win_fill < WIN_BYTES)
        begin
            win_bytes[win_fill] = b;
            win_fill++;
            return;
        end
        w.out_byte    = win_bytes[0];
        w.keep        = 1'b0;
        w.frame_start = 1'b0;
        w.frame_end   = 1'b0;
        if (bytes_to_go == '0)
        begin
            sync    = {win_bytes[0], win_bytes[1][7:4]};
            layer   = win_bytes[1][2:1];
            crc     = ~win_bytes[1][0];
            rate    = win_bytes[2][5:2];
            flen    = {win_bytes[3][1:0], win_bytes[4], win_bytes[5][7:5]};
            min_len = crc ? MIN_LEN_CRC : MIN_LEN_PLAIN;
            if (sync == SYNC_WORD && layer == LAYER_ADTS && rate <= MAX_RATE_INDEX
                && flen >= min_len)
            begin
                latched_hdr.crc_present    = crc;
                latched_hdr.object_profile = win_bytes[2][7:6];
                latched_hdr.channel_config = {win_bytes[2][0], win_bytes[3][7:6]};
                latched_hdr.extra_blocks   = win_bytes[6][1:0];
                latched_hdr.rate_index     = rate;
                latched_hdr.frame_bytes    = flen;
                bytes_to_go   = flen;
                w.frame_start = 1'b1;
            end
        end
        if (bytes_to_go != '0)
        begin
            w.keep      = 1'b1;
            bytes_to_go = bytes_to_go - LEN_W'(1);
            if (bytes_to_go == '0)
            begin
                w.frame_end = 1'b1;
                frame_count = frame_count + COUNT_W'(1);
            end
        end
        for (int i = 0; i < WIN_BYTES - 1; i++)
            win_bytes[i] = win_bytes[i + 1];
        win_bytes[WIN_BYTES - 1] = b;
        w.hdr               = latched_hdr;
        w.samples_per_frame = LEN_W'((32'd1 + latched_hdr.extra_blocks) << SPF_SHIFT);
        w.frames_done       = frame_count;
        pending_words.push_back(w);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        sync_word_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected output word: byte %0d", m_tdata[7:0]);
                fail_count++;
            end
            else
            begin
                w = pending_words.pop_front();
                check_field("out_byte", 32'(w.out_byte), 32'(m_tdata[7:0]));
                check_field("keep", 32'(w.keep), 32'(m_tuser[0]));
                check_field("frame_start", 32'(w.frame_start), 32'(m_tuser[1]));
                check_field("frame_end", 32'(w.frame_end), 32'(m_tlast));
                check_field("frame_bytes", 32'(w.hdr.frame_bytes), 32'(m_tdata[20:8]));
                check_field("rate_index", 32'(w.hdr.rate_index), 32'(m_tdata[24:21]));
                check_field("samples_per_frame", 32'(w.samples_per_frame),
                            32'(m_tdata[37:25]));
                check_field("channel_config", 32'(w.hdr.channel_config),
                            32'(m_tdata[40:38]));
                check_field("object_profile", 32'(w.hdr.object_profile),
                            32'(m_tdata[42:41]));
                check_field("crc_present", 32'(w.hdr.crc_present), 32'(m_tdata[43]));
                check_field("frames_done", w.frames_done, m_tdata[75:44]);
            end
        end
    end

    // receiver: random stalls, or one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_len > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold_len - 1) @(posedge clk);
                rx_hold_len = 0;
            end
            else if (rx_gaps && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_byte(b);
        bytes_sent++;
        if (tx_gaps && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic flush_stage();
        while (stage_bytes.size() > 0)
            send_byte(stage_bytes.pop_front());
    endtask

    task automatic add_random(input int n);
        repeat (n) stage_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_header(input logic [1:0] layer, input logic no_crc,
                              input logic [1:0] profile, input logic [3:0] rate,
                              input logic [2:0] chan, input logic [LEN_W-1:0] flen,
                              input logic [1:0] extra);
        logic [10:0] fullness;
        logic [3:0]  spare;
        fullness = 11'($urandom);
        spare    = 4'($urandom);
        stage_bytes.push_back(8'hFF);
        stage_bytes.push_back({4'hF, 1'($urandom), layer, no_crc});
        stage_bytes.push_back({profile, rate, 1'($urandom), chan[2]});
        stage_bytes.push_back({chan[1:0], spare, flen[12:11]});
        stage_bytes.push_back(flen[10:3]);
        stage_bytes.push_back({flen[2:0], fullness[10:6]});
        stage_bytes.push_back({fullness[5:0], extra});
    endtask

    task automatic add_good_frame();
        logic             no_crc;
        logic [LEN_W-1:0] flen;
        no_crc = 1'($urandom);
        if ($urandom_range(0, 24) == 0)
            flen = LEN_W'($urandom_range(200, 500));
        else
            flen = LEN_W'($urandom_range(no_crc ? 7 : 9, 48));
        add_header(LAYER_ADTS, no_crc, 2'($urandom), 4'($urandom_range(0, 12)),
                   3'($urandom), flen, 2'($urandom));
        add_random(flen - HDR_BYTES);
    endtask

    task automatic add_broken_frame();
        logic             no_crc;
        logic [1:0]       layer;
        logic [3:0]       rate;
        logic [LEN_W-1:0] flen;
        int               base;
        int               kind;
        no_crc = 1'($urandom);
        layer  = LAYER_ADTS;
        rate   = 4'($urandom_range(0, 12));
        flen   = LEN_W'($urandom_range(9, 30));
        kind   = $urandom_range(0, 3);
        base   = stage_bytes.size();
        if (kind == 1)
            layer = 2'($urandom_range(1, 3));
        else if (kind == 2)
            rate = 4'($urandom_range(13, 15));
        else if (kind == 3)
            flen = LEN_W'($urandom_range(0, no_crc ? 6 : 8));
        add_header(layer, no_crc, 2'($urandom), rate, 3'($urandom), flen, 2'($urandom));
        if (kind == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                stage_bytes[base] = 8'($urandom_range(0, 254));
            else
                stage_bytes[base + 1][7:4] = 4'($urandom_range(0, 14));
        end
        add_random($urandom_range(0, 12));
    endtask

    task automatic add_mixed_item();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 6)
            add_good_frame();
        else if (pick <= 8)
            add_broken_frame();
        else
            add_random($urandom_range(1, 12));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // extreme field values, shortest plain and CRC frames, an out-of-range rate
    task automatic test_directed();
        add_header(LAYER_ADTS, 1'b1, 2'd3, MAX_RATE_INDEX, 3'd7, MIN_LEN_PLAIN, 2'd3);
        add_header(LAYER_ADTS, 1'b0, 2'd0, 4'd0, 3'd0, MIN_LEN_CRC, 2'd0);
        add_random(2);
        add_header(LAYER_ADTS, 1'b1, 2'd1, 4'd13, 3'd2, 13'd20, 2'd1);
        flush_stage();
    endtask

    task automatic test_random_stream(input int goal);
        while (bytes_sent < goal)
        begin
            add_mixed_item();
            flush_stage();
        end
    endtask

    // receiver holds off while the sender keeps offering bytes
    task automatic test_long_stall();
        rx_hold_len = 300;
        repeat (8) add_good_frame();
        while (stage_bytes.size() > 60)
            void'(stage_bytes.pop_back());
        flush_stage();
        while (rx_hold_len != 0)
            @(posedge clk);
    endtask

    task automatic test_drain_pause();
        wait_drained();
        repeat (6) add_mixed_item();
        flush_stage();
        wait_drained();
    endtask

    task automatic test_full_rate(input int goal);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        test_random_stream(goal);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_stream(600);
        test_long_stall();
        test_drain_pause();
        test_random_stream(1150);
        test_full_rate(1320);
        wait_drained();
        repeat (FLUSH_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/adts_pkg.sv
rtl/core/adts_window.sv
rtl/core/adts_hdr_check.sv
rtl/core/adts_frame_track.sv
rtl/core/adts_frame_sync.sv
tb/testbench.sv
